[rtl/tcw_pkg.sv]
// tcw_pkg: beat types, operation codes and character codes of the text console writer
// no dependencies; used by text_console_writer_unit

package tcw_pkg;

    // operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // character codes with a meaning of their own
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_NL  = 8'h0A;

    // cell layout
    localparam logic [7:0]  ATTR_NORMAL = 8'h07;
    localparam logic [15:0] BLANK_CELL  = 16'h0720;
    localparam int unsigned TAB_STEP    = 8;

    // configuration port
    localparam int unsigned CFG_DATA_W  = 8;
    localparam logic        CFG_COLUMNS = 1'b0;
    localparam logic        CFG_ROWS    = 1'b1;
    localparam logic [7:0]  COLUMNS_RST = 8'd80;
    localparam logic [5:0]  ROWS_RST    = 6'd25;

    // input beat
    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  char_code;
        logic [11:0] cell_address;
    } t_in_beat;

    // result beat
    typedef struct packed {
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_row;
        logic [11:0] cursor_linear;
        logic [15:0] cell_data;
        logic        scrolled;
    } t_out_beat;

endpackage

[rtl/tcw_mac_unit.sv]
// tcw_mac_unit: shared multiply-add unit, y = a * b + d, for the row-times-columns cell address math
// no dependencies; instantiated by text_console_writer_unit

module tcw_mac_unit #(
    parameter int A_W = 5,
    parameter int B_W = 8,
    parameter int Y_W = 12
) (
    input  logic [A_W-1:0] i_a,
    input  logic [B_W-1:0] i_b,
    input  logic [Y_W-1:0] i_d,
    output logic [Y_W-1:0] o_y
);

    localparam int S_W = A_W + B_W + Y_W + 1;

    logic [S_W-1:0] sum;

    // product plus offset, kept within the address width
    assign sum = S_W'(i_a) * S_W'(i_b) + S_W'(i_d);
    assign o_y = Y_W'(sum);

endmodule

[rtl/tcw_cell_ram.sv]
// tcw_cell_ram: cell store, one write port and one registered read port
// no dependencies; instantiated by text_console_writer_unit

module tcw_cell_ram #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/text_console_writer_unit.sv]
// text_console_writer_unit: top level, cursor sequencer, configuration and result register
// depends on tcw_pkg, tcw_mac_unit and tcw_cell_ram
//
// Usage
//   Input channel (i_in_valid, i_in_beat, o_in_stall) carries one item a beat: write
//   character, clear screen or read cell. Result channel (o_out_valid, o_out_beat,
//   i_out_stall) returns one beat per item with the cursor after the item.
//   Configuration: i_cfg_we with i_cfg_idx (0 columns, 1 rows) and i_cfg_data; a write
//   that leaves the cursor outside the new geometry pulls it back inside.
// Steps, from acceptance to S_LIN, which loads the result register
//   NUL byte or unused operation: S_LIN; read: S_RD; other characters: S_CALC, S_EXEC;
//   a scroll adds S_SCR_LIM, then S_SCR_RD and S_SCR_WR per copied cell ((rows-1)*columns
//   of them) and S_SCR_BLK per blanked cell; clear runs S_CLR over all MAX_COLS*MAX_ROWS
//   cells, one cell a cycle; one item at a time: o_in_stall is high from acceptance
//   until the result is loaded into the output register; all work goes through the
//   single multiply-add unit and the single write port of the store
// Reset: the store is blanked by a sweep of all MAX_COLS*MAX_ROWS cells (4096 at the
//   defaults) during which no item is accepted; configuration writes are taken.
// Stall: a stalled result holds in the output register; the next item is accepted and
//   worked, and its result waits in the last step until the register frees.

module text_console_writer_unit #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  tcw_pkg::t_in_beat              i_in_beat,
    output logic                           o_in_stall,
    output logic                           o_out_valid,
    output tcw_pkg::t_out_beat             o_out_beat,
    input  logic                           i_out_stall,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [tcw_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int ECOL_W = $clog2(MAX_COLS + 1);
    localparam int EROW_W = $clog2(MAX_ROWS + 1);
    localparam int CW1    = COL_W + 1;
    localparam int LW     = ROW_W + 1;
    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int AW     = $clog2(DEPTH);
    localparam int XW     = AW + 12;
    localparam int CCMP_W = ECOL_W + 8;
    localparam int RCMP_W = EROW_W + 6;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    typedef enum logic [10:0] {
        S_INIT    = 11'b00000000001,
        S_IDLE    = 11'b00000000010,
        S_CALC    = 11'b00000000100,
        S_EXEC    = 11'b00000001000,
        S_SCR_LIM = 11'b00000010000,
        S_SCR_RD  = 11'b00000100000,
        S_SCR_WR  = 11'b00001000000,
        S_SCR_BLK = 11'b00010000000,
        S_CLR     = 11'b00100000000,
        S_RD      = 11'b01000000000,
        S_LIN     = 11'b10000000000
    } t_state;

    // effective geometry from a register value
    function automatic logic [ECOL_W-1:0] f_eff_cols(input logic [7:0] v);
        logic [ECOL_W-1:0] res;
        if (v == 8'd0) begin
            res = ECOL_W'(1);
        end else if (CCMP_W'(v) > CCMP_W'(MAX_COLS)) begin
            res = ECOL_W'(MAX_COLS);
        end else begin
            res = ECOL_W'(v);
        end
        return res;
    endfunction

    function automatic logic [EROW_W-1:0] f_eff_rows(input logic [5:0] v);
        logic [EROW_W-1:0] res;
        if (v == 6'd0) begin
            res = EROW_W'(1);
        end else if (RCMP_W'(v) > RCMP_W'(MAX_ROWS)) begin
            res = EROW_W'(MAX_ROWS);
        end else begin
            res = EROW_W'(v);
        end
        return res;
    endfunction

    // registers
    t_state             r_state, n_state;
    logic [7:0]         r_cols, n_cols;
    logic [5:0]         r_rows, n_rows;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_line, n_line;
    logic [AW-1:0]      r_k, n_k;
    logic [COL_W-1:0]   r_bcol, n_bcol;
    logic [AW-1:0]      r_lim, n_lim;
    logic [AW-1:0]      r_waddr, n_waddr;
    logic [15:0]        r_wdata, n_wdata;
    logic               r_wr, n_wr;
    logic               r_scr, n_scr;
    logic               r_rd_ok, n_rd_ok;
    tcw_pkg::t_in_beat  r_in, n_in;
    logic               r_ov, n_ov;
    tcw_pkg::t_out_beat r_out, n_out;

    // geometry in use
    logic [ECOL_W-1:0] eff_c;
    logic [EROW_W-1:0] eff_r;
    logic [COL_W-1:0]  cm1;

    assign eff_c = f_eff_cols(r_cols);
    assign eff_r = f_eff_rows(r_rows);
    assign cm1   = COL_W'(eff_c - 1'b1);

    // shared unit and store ports
    logic [ROW_W-1:0] mac_a;
    logic [AW-1:0]    mac_d;
    logic [AW-1:0]    mac_y;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [15:0]      ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [15:0]      ram_rdata;

    tcw_mac_unit #(
        .A_W (ROW_W),
        .B_W (ECOL_W),
        .Y_W (AW)
    ) u_mac (
        .i_a (mac_a),
        .i_b (eff_c),
        .i_d (mac_d),
        .o_y (mac_y)
    );

    tcw_cell_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (AW),
        .DATA_W (16)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    logic in_acc;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // character decode: new cursor and cell target for a write item
    logic [CW1-1:0]   col_inc;
    logic [CW1-1:0]   tab_sum;
    logic [CW1-1:0]   tab_col;
    logic             line_last;
    logic [COL_W-1:0] c_col, c_tcol;
    logic [ROW_W-1:0] c_line, c_tline;
    logic             c_wr, c_scr;
    logic [15:0]      c_wdata;

    always_comb begin
        logic adv;
        col_inc   = CW1'(r_col) + CW1'(1);
        tab_sum   = CW1'(r_col) + CW1'(tcw_pkg::TAB_STEP);
        tab_col   = tab_sum & ~CW1'(tcw_pkg::TAB_STEP - 1);
        line_last = (LW'(r_line) + LW'(1)) >= LW'(eff_r);
        adv       = 1'b0;
        c_col     = r_col;
        c_line    = r_line;
        c_tcol    = r_col;
        c_tline   = r_line;
        c_wr      = 1'b0;
        c_scr     = 1'b0;
        c_wdata   = tcw_pkg::BLANK_CELL;
        case (r_in.char_code)
            tcw_pkg::CH_NL: begin
                c_col = '0;
                adv   = 1'b1;
            end
            tcw_pkg::CH_BS: begin
                if (r_col != '0 || r_line != '0) begin
                    if (r_col == '0) begin
                        c_tcol  = cm1;
                        c_tline = r_line - 1'b1;
                    end else begin
                        c_tcol = r_col - 1'b1;
                    end
                    c_col  = c_tcol;
                    c_line = c_tline;
                    c_wr   = 1'b1;
                end
            end
            tcw_pkg::CH_TAB: begin
                if (tab_col >= CW1'(eff_c)) begin
                    c_col = '0;
                    adv   = 1'b1;
                end else begin
                    c_col = COL_W'(tab_col);
                end
            end
            default: begin
                c_wr    = 1'b1;
                c_wdata = {tcw_pkg::ATTR_NORMAL, r_in.char_code};
                if (col_inc >= CW1'(eff_c)) begin
                    c_col = '0;
                    adv   = 1'b1;
                end else begin
                    c_col = COL_W'(col_inc);
                end
            end
        endcase
        // next row, or scroll when on the bottom row
        if (adv) begin
            if (line_last) begin
                c_scr = 1'b1;
            end else begin
                c_line = r_line + 1'b1;
            end
        end
    end

    // operand select for the shared unit
    always_comb begin
        mac_a = r_line;
        mac_d = AW'(r_col);
        unique case (r_state)
            S_CALC: begin
                mac_a = c_tline;
                mac_d = AW'(c_tcol);
            end
            S_SCR_LIM: begin
                mac_a = ROW_W'(eff_r - 1'b1);
                mac_d = '0;
            end
            S_SCR_RD: begin
                mac_a = ROW_W'(1);
                mac_d = r_k;
            end
            default: begin
                mac_a = r_line;
                mac_d = AW'(r_col);
            end
        endcase
    end

    // sequencer
    always_comb begin
        logic [ECOL_W-1:0] nc_eff;
        logic [EROW_W-1:0] nr_eff;
        logic              rd_ok;
        n_state   = r_state;
        n_cols    = r_cols;
        n_rows    = r_rows;
        n_col     = r_col;
        n_line    = r_line;
        n_k       = r_k;
        n_bcol    = r_bcol;
        n_lim     = r_lim;
        n_waddr   = r_waddr;
        n_wdata   = r_wdata;
        n_wr      = r_wr;
        n_scr     = r_scr;
        n_rd_ok   = r_rd_ok;
        n_in      = r_in;
        n_ov      = r_ov;
        n_out     = r_out;
        ram_we    = 1'b0;
        ram_waddr = r_k;
        ram_wdata = tcw_pkg::BLANK_CELL;
        ram_re    = 1'b0;
        ram_raddr = mac_y;
        rd_ok     = XW'(r_in.cell_address) < XW'(DEPTH);

        // result beat taken
        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            // blank sweep after reset
            S_INIT: begin
                ram_we = 1'b1;
                n_k    = r_k + 1'b1;
                if (r_k == LAST_ADDR) begin
                    n_k     = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_in    = i_in_beat;
                    n_scr   = 1'b0;
                    n_wr    = 1'b0;
                    n_rd_ok = 1'b0;
                    unique case (i_in_beat.operation)
                        tcw_pkg::OP_WRITE: begin
                            n_state = (i_in_beat.char_code != tcw_pkg::CH_NUL) ? S_CALC
                                                                                : S_LIN;
                        end
                        tcw_pkg::OP_CLEAR: begin
                            n_k     = '0;
                            n_state = S_CLR;
                        end
                        tcw_pkg::OP_READ: begin
                            n_state = S_RD;
                        end
                        default: begin
                            n_state = S_LIN;
                        end
                    endcase
                end
            end
            // cursor update and cell address
            S_CALC: begin
                n_col   = c_col;
                n_line  = c_line;
                n_wr    = c_wr;
                n_wdata = c_wdata;
                n_scr   = c_scr;
                n_waddr = mac_y;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                ram_we    = r_wr;
                ram_waddr = r_waddr;
                ram_wdata = r_wdata;
                n_state   = r_scr ? S_SCR_LIM : S_LIN;
            end
            // scroll: start of the bottom row
            S_SCR_LIM: begin
                n_lim   = mac_y;
                n_k     = '0;
                n_bcol  = '0;
                n_state = (mac_y == '0) ? S_SCR_BLK : S_SCR_RD;
            end
            // scroll: fetch the cell one row below
            S_SCR_RD: begin
                ram_re    = 1'b1;
                ram_raddr = mac_y;
                n_state   = S_SCR_WR;
            end
            S_SCR_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                n_k       = r_k + 1'b1;
                n_state   = ((r_k + 1'b1) == r_lim) ? S_SCR_BLK : S_SCR_RD;
            end
            // scroll: blank the bottom row
            S_SCR_BLK: begin
                ram_we = 1'b1;
                n_k    = r_k + 1'b1;
                n_bcol = r_bcol + 1'b1;
                if (r_bcol == cm1) begin
                    n_state = S_LIN;
                end
            end
            // clear: blank every cell and home the cursor
            S_CLR: begin
                ram_we = 1'b1;
                n_k    = r_k + 1'b1;
                if (r_k == LAST_ADDR) begin
                    n_k     = '0;
                    n_col   = '0;
                    n_line  = '0;
                    n_state = S_LIN;
                end
            end
            S_RD: begin
                n_rd_ok   = rd_ok;
                ram_re    = rd_ok;
                ram_raddr = AW'(r_in.cell_address);
                n_state   = S_LIN;
            end
            // linear cursor and result beat
            S_LIN: begin
                if (!r_ov || !i_out_stall) begin
                    n_out.cursor_column = 7'(r_col);
                    n_out.cursor_row    = 5'(r_line);
                    n_out.cursor_linear = 12'(mac_y);
                    n_out.cell_data     = r_rd_ok ? ram_rdata : 16'd0;
                    n_out.scrolled      = r_scr;
                    n_ov                = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // configuration write, cursor pulled into the new geometry
        nc_eff = eff_c;
        nr_eff = eff_r;
        if (i_cfg_we) begin
            if (i_cfg_idx == tcw_pkg::CFG_COLUMNS) begin
                n_cols = i_cfg_data;
                nc_eff = f_eff_cols(i_cfg_data);
            end else begin
                n_rows = i_cfg_data[5:0];
                nr_eff = f_eff_rows(i_cfg_data[5:0]);
            end
            if (CW1'(n_col) >= CW1'(nc_eff)) begin
                n_col = COL_W'(nc_eff - 1'b1);
            end
            if (LW'(n_line) >= LW'(nr_eff)) begin
                n_line = ROW_W'(nr_eff - 1'b1);
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cols  <= tcw_pkg::COLUMNS_RST;
            r_rows  <= tcw_pkg::ROWS_RST;
            r_col   <= '0;
            r_line  <= '0;
            r_k     <= '0;
            r_bcol  <= '0;
            r_wr    <= 1'b0;
            r_scr   <= 1'b0;
            r_rd_ok <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cols  <= n_cols;
            r_rows  <= n_rows;
            r_col   <= n_col;
            r_line  <= n_line;
            r_k     <= n_k;
            r_bcol  <= n_bcol;
            r_wr    <= n_wr;
            r_scr   <= n_scr;
            r_rd_ok <= n_rd_ok;
            r_ov    <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_lim   <= n_lim;
        r_waddr <= n_waddr;
        r_wdata <= n_wdata;
        r_in    <= n_in;
        r_out   <= n_out;
    end

    assign o_out_valid = r_ov;
    assign o_out_beat  = r_out;

    // cursor stays inside the geometry in use
    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW1'(r_col) < CW1'(eff_c)) && (LW'(r_line) < LW'(eff_r)))
        else $error("cursor outside geometry");

    // store writes stay inside the store
    a_write_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (ram_waddr <= LAST_ADDR))
        else $error("cell write beyond store");

    // scroll copy reads ahead of the cell it writes
    a_scroll_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCR_RD) |-> (mac_y > r_k))
        else $error("scroll source not above destination");

endmodule

[bench/text_console_writer_unit_test.sv]
// text_console_writer_unit_test: self-checking bench for the text console writer
// depends on tcw_pkg and text_console_writer_unit; predicts cursor, scroll and cell reads
`timescale 1ns / 100ps

module text_console_writer_unit_test;

    localparam int unsigned MAX_COLS   = 128;
    localparam int unsigned MAX_ROWS   = 32;
    localparam int unsigned CELL_COUNT = MAX_COLS * MAX_ROWS;
    localparam logic [1:0]  OP_UNUSED  = 2'd3;

    // expected screen, cursor and geometry, plus the beats still owed by the block
    class console_scoreboard;
        logic [15:0] screen_cells [CELL_COUNT];
        int unsigned cur_col;
        int unsigned cur_line;
        logic [7:0]  columns_reg;
        logic [5:0]  rows_reg;
        tcw_pkg::t_out_beat reports_due [$];
        int unsigned n_items, n_checked, n_fail, n_scrolls, n_reads, n_clears;

        function new();
            foreach (screen_cells[i]) screen_cells[i] = tcw_pkg::BLANK_CELL;
            cur_col     = 0;
            cur_line    = 0;
            columns_reg = tcw_pkg::COLUMNS_RST;
            rows_reg    = tcw_pkg::ROWS_RST;
            n_items     = 0;
            n_checked   = 0;
            n_fail      = 0;
            n_scrolls   = 0;
            n_reads     = 0;
            n_clears    = 0;
        endfunction

        function int unsigned used_cols();
            if (columns_reg == 0) return 1;
            if (columns_reg > MAX_COLS) return MAX_COLS;
            return columns_reg;
        endfunction

        function int unsigned used_rows();
            if (rows_reg == 0) return 1;
            if (rows_reg > MAX_ROWS) return MAX_ROWS;
            return rows_reg;
        endfunction

        // pull the cursor back inside the geometry in use
        function void clamp_cursor();
            if (cur_col >= used_cols()) cur_col = used_cols() - 1;
            if (cur_line >= used_rows()) cur_line = used_rows() - 1;
        endfunction

        function void write_register(logic idx, logic [7:0] val);
            if (idx == tcw_pkg::CFG_COLUMNS) columns_reg = val;
            else rows_reg = val[5:0];
            clamp_cursor();
        endfunction

        // move every row up one line inside the geometry and blank the bottom row
        function void scroll_screen(int unsigned c, int unsigned r);
            for (int unsigned j = 1; j < r; j++)
                for (int unsigned i = 0; i < c; i++)
                    screen_cells[(j - 1) * c + i] = screen_cells[j * c + i];
            for (int unsigned i = 0; i < c; i++)
                screen_cells[(r - 1) * c + i] = tcw_pkg::BLANK_CELL;
        endfunction

        // work out the result beat of one accepted item
        function void apply_item(tcw_pkg::t_in_beat b);
            int unsigned c;
            int unsigned r;
            logic [15:0] data;
            logic        scr;
            tcw_pkg::t_out_beat want;
            c    = used_cols();
            r    = used_rows();
            data = '0;
            scr  = 1'b0;
            n_items++;
            clamp_cursor();
            if (b.operation == tcw_pkg::OP_WRITE && b.char_code != tcw_pkg::CH_NUL) begin
                case (b.char_code)
                    tcw_pkg::CH_NL: begin
                        cur_col = 0;
                        cur_line++;
                    end
                    tcw_pkg::CH_BS: begin
                        // nothing happens at the origin
                        if (cur_col != 0 || cur_line != 0) begin
                            if (cur_col == 0) begin
                                cur_col = c - 1;
                                cur_line--;
                            end else begin
                                cur_col--;
                            end
                            screen_cells[cur_line * c + cur_col] = tcw_pkg::BLANK_CELL;
                        end
                    end
                    tcw_pkg::CH_TAB: begin
                        cur_col = (cur_col + tcw_pkg::TAB_STEP) & ~(tcw_pkg::TAB_STEP - 1);
                        if (cur_col >= c) begin
                            cur_col = 0;
                            cur_line++;
                        end
                    end
                    default: begin
                        screen_cells[cur_line * c + cur_col] =
                            {tcw_pkg::ATTR_NORMAL, b.char_code};
                        cur_col++;
                        if (cur_col >= c) begin
                            cur_col = 0;
                            cur_line++;
                        end
                    end
                endcase
                if (cur_line >= r) begin
                    scroll_screen(c, r);
                    cur_line = r - 1;
                    scr = 1'b1;
                    n_scrolls++;
                end
            end else if (b.operation == tcw_pkg::OP_CLEAR) begin
                foreach (screen_cells[i]) screen_cells[i] = tcw_pkg::BLANK_CELL;
                cur_col  = 0;
                cur_line = 0;
                n_clears++;
            end else if (b.operation == tcw_pkg::OP_READ) begin
                data = screen_cells[b.cell_address];
                n_reads++;
            end
            want.cursor_column = 7'(cur_col);
            want.cursor_row    = 5'(cur_line);
            want.cursor_linear = 12'(cur_line * c + cur_col);
            want.cell_data     = data;
            want.scrolled      = scr;
            reports_due.push_back(want);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                n_fail++;
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        // compare one result beat with the oldest expectation
        function void check_report(tcw_pkg::t_out_beat got);
            tcw_pkg::t_out_beat want;
            if (reports_due.size() == 0) begin
                n_fail++;
                $display("%0t: result beat with no item pending, expected none actual %h",
                         $time, got);
                return;
            end
            want = reports_due.pop_front();
            n_checked++;
            compare_field("cursor_column", want.cursor_column, got.cursor_column);
            compare_field("cursor_row", want.cursor_row, got.cursor_row);
            compare_field("cursor_linear", want.cursor_linear, got.cursor_linear);
            compare_field("cell_data", want.cell_data, got.cell_data);
            compare_field("scrolled", want.scrolled, got.scrolled);
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    tcw_pkg::t_in_beat  in_beat   = '0;
    logic               in_stall;
    logic               out_valid;
    tcw_pkg::t_out_beat out_beat;
    logic               out_stall = 1'b0;
    logic               cfg_we    = 1'b0;
    logic               cfg_idx   = tcw_pkg::CFG_COLUMNS;
    logic [7:0]         cfg_data  = '0;

    console_scoreboard sb;
    bit          quiet_tail = 1'b0;
    int unsigned n_geometries = 0;

    text_console_writer_unit #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_beat  (in_beat),
        .o_in_stall (in_stall),
        .o_out_valid(out_valid),
        .o_out_beat (out_beat),
        .i_out_stall(out_stall),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    initial begin
        #60_000_000;
        $display("Verification failed");
        $finish;
    end

    // result monitor
    always @(posedge clk) begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            sb.check_report(out_beat);
    end

    // result side stall: short random bursts, free stretches, one long hold-off
    initial begin : result_stall
        int unsigned len;
        bit          held_off;
        held_off = 1'b0;
        @(posedge clk);
        forever begin
            if (!held_off && !quiet_tail && sb.n_checked >= 100) begin
                held_off = 1'b1;
                out_stall <= 1'b1;
                len = 300;
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                len = $urandom_range(1, 6);
            end else begin
                out_stall <= 1'b0;
                len = $urandom_range(1, 20);
            end
            repeat (len) @(posedge clk);
        end
    end

    function automatic tcw_pkg::t_in_beat make_beat(logic [1:0] op, logic [7:0] ch,
                                                    logic [11:0] addr);
        tcw_pkg::t_in_beat b;
        b.operation    = op;
        b.char_code    = ch;
        b.cell_address = addr;
        return b;
    endfunction

    // random item: mostly character writes, with reads, clears and unused codes
    function automatic tcw_pkg::t_in_beat random_beat(int unsigned nl_pct);
        int unsigned sel;
        int unsigned pick;
        int unsigned span;
        tcw_pkg::t_in_beat b;
        b    = make_beat(tcw_pkg::OP_WRITE, 8'($urandom_range(0, 255)),
                         12'($urandom_range(0, 4095)));
        sel  = $urandom_range(0, 99);
        span = sb.used_cols() * sb.used_rows();
        if (sel < 3) begin
            b.operation = tcw_pkg::OP_CLEAR;
        end else if (sel < 18) begin
            b.operation = tcw_pkg::OP_READ;
            if ($urandom_range(0, 1) == 1) b.cell_address = 12'($urandom_range(0, span - 1));
        end else if (sel < 20) begin
            b.operation = OP_UNUSED;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < nl_pct) b.char_code = tcw_pkg::CH_NL;
            else if (pick < nl_pct + 8) b.char_code = tcw_pkg::CH_BS;
            else if (pick < nl_pct + 16) b.char_code = tcw_pkg::CH_TAB;
            else if (pick < nl_pct + 19) b.char_code = tcw_pkg::CH_NUL;
        end
        return b;
    endfunction

    // offer one beat, sometimes after a random gap, until it is taken
    task automatic send_item(input tcw_pkg::t_in_beat b);
        int unsigned gap;
        gap = 0;
        if (!quiet_tail && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.apply_item(b);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_register(idx, val);
    endtask

    // drain the block, let it settle, then load both geometry registers
    task automatic set_geometry(input logic [7:0] cols, input logic [5:0] nrows);
        in_valid <= 1'b0;
        while (sb.reports_due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if ($urandom_range(0, 1) == 1) begin
            write_reg(tcw_pkg::CFG_COLUMNS, cols);
            write_reg(tcw_pkg::CFG_ROWS, {2'b00, nrows});
        end else begin
            write_reg(tcw_pkg::CFG_ROWS, {2'b00, nrows});
            write_reg(tcw_pkg::CFG_COLUMNS, cols);
        end
        n_geometries++;
    endtask

    task automatic run_phase(input logic [7:0] cols, input logic [5:0] nrows,
                             input int unsigned count, input int unsigned nl_pct);
        set_geometry(cols, nrows);
        repeat (count) send_item(random_beat(nl_pct));
    endtask

    initial begin : stimulus
        int unsigned wait_cycles;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed items at the reset geometry
        send_item(make_beat(tcw_pkg::OP_READ, tcw_pkg::CH_NUL, 12'd0));
        send_item(make_beat(tcw_pkg::OP_WRITE, 8'h41, 12'd0));
        send_item(make_beat(tcw_pkg::OP_WRITE, 8'hFF, 12'hFFF));
        send_item(make_beat(tcw_pkg::OP_WRITE, 8'h80, 12'd0));
        send_item(make_beat(tcw_pkg::OP_WRITE, tcw_pkg::CH_NUL, 12'd0));
        send_item(make_beat(tcw_pkg::OP_READ, tcw_pkg::CH_NUL, 12'd1));
        send_item(make_beat(tcw_pkg::OP_WRITE, tcw_pkg::CH_BS, 12'd0));
        send_item(make_beat(tcw_pkg::OP_WRITE, tcw_pkg::CH_TAB, 12'd0));
        send_item(make_beat(tcw_pkg::OP_WRITE, tcw_pkg::CH_NL, 12'd0));
        // backspace at column 0 wraps to the end of the row above
        send_item(make_beat(tcw_pkg::OP_WRITE, tcw_pkg::CH_BS, 12'd0));
        send_item(make_beat(tcw_pkg::OP_READ, tcw_pkg::CH_NUL, 12'd79));
        send_item(make_beat(OP_UNUSED, 8'h5A, 12'hFFF));
        send_item(make_beat(tcw_pkg::OP_WRITE, 8'h7F, 12'd0));
        send_item(make_beat(tcw_pkg::OP_CLEAR, 8'hFF, 12'hFFF));
        send_item(make_beat(tcw_pkg::OP_WRITE, tcw_pkg::CH_BS, 12'd0));
        send_item(make_beat(tcw_pkg::OP_READ, tcw_pkg::CH_NUL, 12'hFFF));
        send_item(make_beat(tcw_pkg::OP_READ, 8'hFF, 12'd2));

        // zero columns and rows act as a single cell; writes, tabs and newlines scroll
        set_geometry(8'd0, 6'd0);
        send_item(make_beat(tcw_pkg::OP_WRITE, 8'h78, 12'd0));
        send_item(make_beat(tcw_pkg::OP_WRITE, tcw_pkg::CH_TAB, 12'd0));
        send_item(make_beat(tcw_pkg::OP_WRITE, tcw_pkg::CH_NL, 12'd0));
        send_item(make_beat(tcw_pkg::OP_WRITE, tcw_pkg::CH_BS, 12'd0));
        send_item(make_beat(tcw_pkg::OP_READ, tcw_pkg::CH_NUL, 12'd0));

        // random phases over a spread of geometries
        run_phase(8'd8, 6'd4, 70, 15);
        run_phase(8'd2, 6'd2, 25, 10);
        run_phase(8'd255, 6'd63, 60, 70);
        run_phase(8'd1, 6'd32, 40, 10);
        run_phase(8'd128, 6'd1, 40, 10);
        repeat (3) run_phase(8'($urandom_range(1, 24)), 6'($urandom_range(1, 6)), 30, 15);
        run_phase(8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)), 30, 10);
        quiet_tail = 1'b1;
        run_phase(8'd13, 6'd5, 60, 15);

        // drain and settle
        in_valid <= 1'b0;
        for (wait_cycles = 0; wait_cycles < 20000 && sb.reports_due.size() != 0;
             wait_cycles++)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.reports_due.size() != 0) begin
            $display("%0t: %0d result beats expected actual none", $time,
                     sb.reports_due.size());
            sb.n_fail += sb.reports_due.size();
        end

        $display("%0d items over %0d geometries, %0d result beats checked",
                 sb.n_items, n_geometries + 1, sb.n_checked);
        $display("%0d scrolls, %0d cell reads, %0d clears, %0d mismatches",
                 sb.n_scrolls, sb.n_reads, sb.n_clears, sb.n_fail);
        if (sb.n_fail == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
